// ----- design/mmc3_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmc3_pkg
// Shared types and codes for the bank mapper with scanline interrupt counter.
// ----------------------------------------------------------------------------
package mmc3_pkg;

    // request kinds on the input channel
    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_PRG   = 2'd1,
        ACT_CHR   = 2'd2,
        ACT_TICK  = 2'd3
    } action_t;

    // register port decoded from address bits 14, 13 and 0
    typedef enum logic [2:0] {
        WR_SELECT  = 3'd0,
        WR_DATA    = 3'd1,
        WR_MIRROR  = 3'd2,
        WR_PROTECT = 3'd3,
        WR_PERIOD  = 3'd4,
        WR_CLEAR   = 3'd5,
        WR_DISABLE = 3'd6,
        WR_ENABLE  = 3'd7
    } wr_code_t;

    // configuration register indexes
    localparam logic [7:0] CFG_PRG_BANK_COUNT = 8'd0;
    localparam logic [7:0] CFG_MIRROR_DEFAULT = 8'd1;

    localparam logic [7:0] PRG_BANK_COUNT_RESET = 8'd2;
    localparam logic       MIRROR_RESET         = 1'b0;

    // character pair masks
    localparam logic [7:0] CHR_EVEN_MASK = 8'hfe;
    localparam logic [7:0] CHR_ODD_BIT   = 8'h01;

    // mapping state seen by the translator
    typedef struct packed {
        logic [7:0]       bank_select;
        logic [7:0][7:0]  bank_regs;
        logic [7:0]       prg_bank_count;
    } map_state_t;

endpackage
`default_nettype wire

// ----- design/mmc3_xlate.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmc3_xlate
// Program and character window translation to a ROM bank and offset.
// ----------------------------------------------------------------------------
module mmc3_xlate (
    input  wire mmc3_pkg::action_t    action,
    input  wire logic [14:0]          address,
    input  wire mmc3_pkg::map_state_t map_state,
    output logic [6:0]                bank,
    output logic [13:0]               offset,
    output logic                      bad_address
);

    logic [1:0] prg_win;
    logic [6:0] prg_last;
    logic       prg_mode;
    logic [7:0] prg_reg;
    logic [6:0] prg_bank;
    logic       prg_half;

    logic [2:0] chr_win;
    logic [2:0] chr_idx;
    logic [7:0] chr_raw;
    logic [7:0] chr_val;

    // program window selection
    always_comb begin
        prg_win  = address[14:13];
        prg_last = 7'(map_state.prg_bank_count - 8'd1);
        prg_mode = map_state.bank_select[6];
        prg_reg  = map_state.bank_regs[6];
        prg_bank = prg_last;
        prg_half = 1'b0;
        if (prg_win == 2'd3) begin
            prg_bank = prg_last;
            prg_half = 1'b1;
        end else if (prg_win == 2'd1) begin
            prg_reg  = map_state.bank_regs[7];
            prg_bank = prg_reg[7:1];
            prg_half = prg_reg[0];
        end else if ((prg_win == 2'd0) == !prg_mode) begin
            prg_bank = prg_reg[7:1];
            prg_half = prg_reg[0];
        end
    end

    // character window selection, mode bit swaps lower and upper halves
    always_comb begin
        chr_win = address[12:10] ^ {map_state.bank_select[7], 2'b00};
        if (!chr_win[2]) begin
            chr_idx = {2'b00, chr_win[1]};
        end else begin
            chr_idx = chr_win - 3'd2;
        end
        chr_raw = map_state.bank_regs[chr_idx];
        if (chr_win[2]) begin
            chr_val = chr_raw;
        end else if (chr_win[0]) begin
            chr_val = chr_raw | mmc3_pkg::CHR_ODD_BIT;
        end else begin
            chr_val = chr_raw & mmc3_pkg::CHR_EVEN_MASK;
        end
    end

    // result fields by request kind
    always_comb begin
        bank        = '0;
        offset      = '0;
        bad_address = 1'b0;
        unique case (action)
            mmc3_pkg::ACT_PRG: begin
                bank   = prg_bank;
                offset = {prg_half, address[12:0]};
            end
            mmc3_pkg::ACT_CHR: begin
                if (address[14:13] != 2'b00) begin
                    bad_address = 1'b1;
                end else begin
                    bank   = {2'b00, chr_val[7:3]};
                    offset = {1'b0, chr_val[2:0], address[9:0]};
                end
            end
            mmc3_pkg::ACT_WRITE, mmc3_pkg::ACT_TICK: begin
                bank   = '0;
                offset = '0;
            end
            default: begin
                bank   = '0;
                offset = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/mmc3_state.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmc3_state
// Mapper registers, interrupt counter and configuration straps.
// ----------------------------------------------------------------------------
module mmc3_state (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration write
    input  wire logic                 cfg_write,
    input  wire logic [7:0]           cfg_index,
    input  wire logic [7:0]           cfg_data,
    // request being retired this cycle
    input  wire logic                 step,
    input  wire mmc3_pkg::action_t    action,
    input  wire logic [14:0]          address,
    input  wire logic [7:0]           value,
    // state before this request, and flags it produces
    output mmc3_pkg::map_state_t      map_state,
    output logic                      mirror_next,
    output logic                      irq_request,
    output logic                      irq_ack
);

    logic [7:0]      bank_select_reg,    bank_select_next;
    logic [7:0][7:0] bank_regs_reg,      bank_regs_next;
    logic [7:0]      prg_bank_count_reg, prg_bank_count_next;
    logic            mirror_default_reg, mirror_default_next;
    logic            mirror_reg,         mirror_next_int;
    logic [7:0]      irq_period_reg,     irq_period_next;
    logic [7:0]      irq_count_reg,      irq_count_next;
    logic            irq_on_reg,         irq_on_next;

    mmc3_pkg::wr_code_t wr_code;
    logic [7:0]         tick_count;

    assign wr_code  = mmc3_pkg::wr_code_t'({address[14:13], address[0]});
    // counter value after a tick
    assign tick_count = (irq_count_reg == 8'd0) ? irq_period_reg
                                                : irq_count_reg - 8'd1;

    // next state for register writes, ticks and configuration
    always_comb begin
        bank_select_next    = bank_select_reg;
        bank_regs_next      = bank_regs_reg;
        prg_bank_count_next = prg_bank_count_reg;
        mirror_default_next = mirror_default_reg;
        mirror_next_int     = mirror_reg;
        irq_period_next     = irq_period_reg;
        irq_count_next      = irq_count_reg;
        irq_on_next         = irq_on_reg;
        irq_request         = 1'b0;
        irq_ack             = 1'b0;

        if (step && action == mmc3_pkg::ACT_WRITE) begin
            unique case (wr_code)
                mmc3_pkg::WR_SELECT:  bank_select_next = value;
                mmc3_pkg::WR_DATA:    bank_regs_next[bank_select_reg[2:0]] = value;
                mmc3_pkg::WR_MIRROR:  mirror_next_int = value[0];
                // ram protect is not modeled
                mmc3_pkg::WR_PROTECT: irq_on_next = irq_on_reg;
                mmc3_pkg::WR_PERIOD:  irq_period_next = value;
                mmc3_pkg::WR_CLEAR:   irq_count_next = 8'd0;
                mmc3_pkg::WR_DISABLE: begin
                    irq_ack     = irq_on_reg;
                    irq_on_next = 1'b0;
                end
                mmc3_pkg::WR_ENABLE:  irq_on_next = 1'b1;
                default:              irq_on_next = irq_on_reg;
            endcase
        end else if (step && action == mmc3_pkg::ACT_TICK) begin
            irq_count_next = tick_count;
            irq_request    = irq_on_reg && (tick_count == 8'd0);
        end

        // straps, only to be written while idle by the user; the block does not enforce it
        if (cfg_write) begin
            if (cfg_index == mmc3_pkg::CFG_PRG_BANK_COUNT) begin
                prg_bank_count_next = cfg_data;
            end else if (cfg_index == mmc3_pkg::CFG_MIRROR_DEFAULT) begin
                mirror_default_next = cfg_data[0];
                mirror_next_int     = cfg_data[0];
            end
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_select_reg    <= '0;
            bank_regs_reg      <= '0;
            prg_bank_count_reg <= mmc3_pkg::PRG_BANK_COUNT_RESET;
            mirror_default_reg <= mmc3_pkg::MIRROR_RESET;
            mirror_reg         <= mmc3_pkg::MIRROR_RESET;
            irq_period_reg     <= '0;
            irq_count_reg      <= '0;
            irq_on_reg         <= 1'b0;
        end else begin
            bank_select_reg    <= bank_select_next;
            bank_regs_reg      <= bank_regs_next;
            prg_bank_count_reg <= prg_bank_count_next;
            mirror_default_reg <= mirror_default_next;
            mirror_reg         <= mirror_next_int;
            irq_period_reg     <= irq_period_next;
            irq_count_reg      <= irq_count_next;
            irq_on_reg         <= irq_on_next;
        end
    end

    assign map_state.bank_select    = bank_select_reg;
    assign map_state.bank_regs      = bank_regs_reg;
    assign map_state.prg_bank_count = prg_bank_count_reg;
    assign mirror_next              = mirror_next_int;

    // disable write always leaves interrupts off
    a_disable_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && action == mmc3_pkg::ACT_WRITE && wr_code == mmc3_pkg::WR_DISABLE
         && !cfg_write) |=> !irq_on_reg)
        else $error("irq enable still set after disable write");

    // a tick on a running counter counts down by one
    a_tick_decrement: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && action == mmc3_pkg::ACT_TICK && irq_count_reg != 8'd0 && !cfg_write)
        |=> irq_count_reg == $past(irq_count_reg) - 8'd1)
        else $error("irq counter did not decrement on tick");

endmodule
`default_nettype wire

// ----- design/mmc3_bank_mapper_irq_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mmc3_bank_mapper_irq_unit
// Cartridge bank mapper with scanline interrupt counter, streaming wrapper.
// ----------------------------------------------------------------------------
// Every request (register write, program translate, character translate or
// scanline tick) yields exactly one result. Throughput is one request per
// clock while m_tready keeps the result register draining. An accepted
// request is held in the input register; the translate and register update
// logic feeds the result register when it advances, and m_tvalid comes from
// the result register. The result register lets a new request enter while
// the previous result waits on m_tready; with both registers full and
// m_tready low the input stalls. RAM protect writes are taken and have no
// effect. The result's mirroring bit reflects any mirroring write carried
// by that same request.
module mmc3_bank_mapper_irq_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration writes
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    // request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // address[14:0], value[22:15], zero pad
    input  wire logic [1:0]  s_tuser,   // action[1:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // bank[6:0], offset[20:7], mirroring[21],
                                        // irq_request[22], irq_ack[23],
                                        // bad_address[24], zero pad
);

    logic               in_valid_reg,   in_valid_next;
    mmc3_pkg::action_t  in_action_reg;
    logic [14:0]        in_address_reg;
    logic [7:0]         in_value_reg;

    logic               out_valid_reg,  out_valid_next;
    logic [6:0]         out_bank_reg;
    logic [13:0]        out_offset_reg;
    logic               out_mirror_reg;
    logic               out_req_reg;
    logic               out_ack_reg;
    logic               out_bad_reg;

    logic                 advance;
    logic                 in_take;
    mmc3_pkg::map_state_t map_state;
    logic                 mirror_next;
    logic                 irq_request;
    logic                 irq_ack;
    logic [6:0]           bank;
    logic [13:0]          offset;
    logic                 bad_address;

    // handshake control
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign in_take   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_action_reg  <= mmc3_pkg::action_t'(s_tuser);
            in_address_reg <= s_tdata[14:0];
            in_value_reg   <= s_tdata[22:15];
        end
    end

    mmc3_state u_state (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .step        (advance),
        .action      (in_action_reg),
        .address     (in_address_reg),
        .value       (in_value_reg),
        .map_state   (map_state),
        .mirror_next (mirror_next),
        .irq_request (irq_request),
        .irq_ack     (irq_ack)
    );

    mmc3_xlate u_xlate (
        .action      (in_action_reg),
        .address     (in_address_reg),
        .map_state   (map_state),
        .bank        (bank),
        .offset      (offset),
        .bad_address (bad_address)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_bank_reg   <= bank;
            out_offset_reg <= offset;
            out_mirror_reg <= mirror_next;
            out_req_reg    <= irq_request;
            out_ack_reg    <= irq_ack;
            out_bad_reg    <= bad_address;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_bad_reg, out_ack_reg, out_req_reg, out_mirror_reg,
                       out_offset_reg, out_bank_reg};

    // only one kind of flag can come from one request
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $countones({out_req_reg, out_ack_reg, out_bad_reg}) <= 1)
        else $error("more than one request flag set in one result");

    // a bad character address carries no bank or offset
    a_bad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_bad_reg) |-> (out_bank_reg == 7'd0 && out_offset_reg == 14'd0))
        else $error("bad address result with nonzero bank or offset");

    // input stalls only when both stages are full and the sink holds off
    a_stall_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

endmodule
`default_nettype wire

// ----- tb/sv/mmc3_bank_mapper_irq_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc3_bank_mapper_irq_unit_tb
// Self-checking bench for the bank mapper with scanline interrupt counter.
// A queue-fed driver offers requests on the input stream and a monitor
// predicts every result from a model of the mapper state. Each returned result
// is compared field by field with the oldest prediction. The run goes through
// a directed pass and then random phases under several bank counts and
// mirroring straps. Both stream sides stall at random, and once the result
// side holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module mmc3_bank_mapper_irq_unit_tb;
    import mmc3_pkg::*;

    // register port addresses, bits 14, 13 and 0 select the port
    localparam logic [14:0] ADDR_SELECT  = 15'h0000;
    localparam logic [14:0] ADDR_DATA    = 15'h0001;
    localparam logic [14:0] ADDR_MIRROR  = 15'h2000;
    localparam logic [14:0] ADDR_PROTECT = 15'h2001;
    localparam logic [14:0] ADDR_PERIOD  = 15'h4000;
    localparam logic [14:0] ADDR_CLEAR   = 15'h4001;
    localparam logic [14:0] ADDR_DISABLE = 15'h6000;
    localparam logic [14:0] ADDR_ENABLE  = 15'h6001;

    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 330;
    localparam int HOLD_AT       = 700;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 10;

    typedef struct {
        action_t     act;
        logic [14:0] addr;
        logic [7:0]  val;
    } bus_req_t;

    typedef struct {
        logic [6:0]  bank;
        logic [13:0] offset;
        logic        mirroring;
        logic        irq_request;
        logic        irq_ack;
        logic        bad_address;
    } mapped_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;

    // mapper model state
    logic [7:0]      sel_reg;
    logic [7:0]      bank_file [8];
    logic            mirror_bit;
    logic [7:0]      protect_reg;
    logic [7:0]      period_reg;
    logic [7:0]      count_reg;
    logic            irq_enabled;
    logic [7:0]      prg_count;
    logic            mirror_strap;

    bus_req_t        pending_reqs[$];
    mapped_result_t  due_results[$];
    int              mismatches    = 0;
    int              idle_pct      = 32;
    int              taken_results = 0;
    int              hold_left     = 0;
    bit              hold_done     = 1'b0;

    mmc3_bank_mapper_irq_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    initial begin
        forever #5 aclk = ~aclk;
    end

    // program window to 16 KB bank and offset
    function automatic mapped_result_t map_prg(logic [14:0] addr);
        mapped_result_t r;
        logic [7:0]     last_m1;
        logic [6:0]     last;
        logic [1:0]     win;
        logic           mode;
        logic           half;
        logic [6:0]     b;
        r = '{default: '0};
        last_m1 = prg_count - 8'd1;
        last = last_m1[6:0];
        win = addr[14:13];
        mode = sel_reg[6];
        if (win == 2'd3) begin
            b = last;
            half = 1'b1;
        end else if (win == 2'd1) begin
            b = bank_file[7][7:1];
            half = bank_file[7][0];
        end else if ((win == 2'd0) == (mode == 1'b0)) begin
            b = bank_file[6][7:1];
            half = bank_file[6][0];
        end else begin
            b = last;
            half = 1'b0;
        end
        r.bank = b;
        r.offset = {half, addr[12:0]};
        return r;
    endfunction

    // character window to 8 KB bank and offset, flags out-of-range addresses
    function automatic mapped_result_t map_chr(logic [14:0] addr);
        mapped_result_t r;
        logic [2:0]     win;
        logic [7:0]     v;
        r = '{default: '0};
        if (addr > 15'h1fff) begin
            r.bad_address = 1'b1;
        end else begin
            win = addr[12:10];
            if (sel_reg[7])
                win = win ^ 3'd4;
            if (win < 3'd4) begin
                v = bank_file[win >> 1];
                v = win[0] ? (v | CHR_ODD_BIT) : (v & CHR_EVEN_MASK);
            end else begin
                v = bank_file[win - 3'd2];
            end
            r.bank = {2'b00, v[7:3]};
            r.offset = {1'b0, v[2:0], addr[9:0]};
        end
        return r;
    endfunction

    // apply one request to the model and return the result it causes
    function automatic mapped_result_t mapper_step(bus_req_t q);
        mapped_result_t r;
        r = '{default: '0};
        case (q.act)
            ACT_WRITE: begin
                case (wr_code_t'({q.addr[14], q.addr[13], q.addr[0]}))
                    WR_SELECT:  sel_reg = q.val;
                    WR_DATA:    bank_file[sel_reg[2:0]] = q.val;
                    WR_MIRROR:  mirror_bit = q.val[0];
                    WR_PROTECT: protect_reg = q.val;
                    WR_PERIOD:  period_reg = q.val;
                    WR_CLEAR:   count_reg = 8'd0;
                    WR_DISABLE: begin
                        r.irq_ack = irq_enabled;
                        irq_enabled = 1'b0;
                    end
                    default:    irq_enabled = 1'b1;
                endcase
            end
            ACT_PRG: r = map_prg(q.addr);
            ACT_CHR: r = map_chr(q.addr);
            default: begin
                if (count_reg == 8'd0)
                    count_reg = period_reg;
                else
                    count_reg = count_reg - 8'd1;
                r.irq_request = irq_enabled && (count_reg == 8'd0);
            end
        endcase
        r.mirroring = mirror_bit;
        return r;
    endfunction

    function automatic void reset_mapper_model();
        prg_count = PRG_BANK_COUNT_RESET;
        mirror_strap = MIRROR_RESET;
        sel_reg = 8'd0;
        foreach (bank_file[i])
            bank_file[i] = 8'd0;
        mirror_bit = mirror_strap;
        protect_reg = 8'd0;
        period_reg = 8'd0;
        count_reg = 8'd0;
        irq_enabled = 1'b0;
    endfunction

    task automatic queue_req(action_t act, logic [14:0] addr, logic [7:0] val);
        bus_req_t q;
        q.act = act;
        q.addr = addr;
        q.val = val;
        pending_reqs.push_back(q);
    endtask

    // random request, register traffic aimed at real ports is the largest share
    task automatic queue_random_req();
        int          pick;
        wr_code_t    code;
        logic [14:0] addr;
        logic [7:0]  val;
        pick = $urandom_range(99);
        addr = 15'($urandom_range(32767));
        val = 8'($urandom_range(255));
        if (pick < 40) begin
            code = wr_code_t'($urandom_range(7));
            addr[14] = code[2];
            addr[13] = code[1];
            addr[0] = code[0];
            // short periods so the counter hits zero often
            if (code == WR_PERIOD && $urandom_range(99) < 70)
                val = 8'($urandom_range(5));
            queue_req(ACT_WRITE, addr, val);
        end else if (pick < 60) begin
            queue_req(ACT_PRG, addr, val);
        end else if (pick < 80) begin
            if ($urandom_range(99) < 85)
                addr[14:13] = 2'b00;
            queue_req(ACT_CHR, addr, val);
        end else begin
            queue_req(ACT_TICK, addr, val);
        end
    endtask

    task automatic write_cfg(logic [7:0] index, logic [7:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == CFG_PRG_BANK_COUNT) begin
            prg_count = data;
        end else if (index == CFG_MIRROR_DEFAULT) begin
            mirror_strap = data[0];
            mirror_bit = mirror_strap;
        end
    endtask

    // wait until no request is queued, offered or owed a result
    task automatic wait_drained();
        while (pending_reqs.size() != 0 || due_results.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            if (mismatches < MAX_REPORTS)
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    // request driver: holds an offered request until it is taken
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                pending_reqs.delete(0);
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {1'b0, pending_reqs[0].val, pending_reqs[0].addr};
                    s_tuser <= pending_reqs[0].act;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                taken_results++;
                if (taken_results == HOLD_AT && !hold_done) begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    // monitor: predict on accepted requests, check returned results
    always @(posedge aclk) begin
        bus_req_t       q;
        mapped_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                q.act = action_t'(s_tuser);
                q.addr = s_tdata[14:0];
                q.val = s_tdata[22:15];
                due_results.push_back(mapper_step(q));
            end
            if (m_tvalid && m_tready) begin
                if (due_results.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("unexpected result %08h", m_tdata);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    check_field("bank", want.bank, m_tdata[6:0]);
                    check_field("offset", want.offset, m_tdata[20:7]);
                    check_field("mirroring", want.mirroring, m_tdata[21]);
                    check_field("irq_request", want.irq_request, m_tdata[22]);
                    check_field("irq_ack", want.irq_ack, m_tdata[23]);
                    check_field("bad_address", want.bad_address, m_tdata[24]);
                end
            end
        end
    end

    // stimulus and configuration phases
    initial begin
        logic [7:0] prg_counts [PHASES];
        logic       straps     [PHASES];
        reset_mapper_model();
        prg_counts = '{8'd1, 8'd128, 8'd0, 8'd255, 8'd2, 8'd2};
        straps = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
        prg_counts[4] = 8'($urandom_range(1, 128));
        straps[4] = 1'($urandom_range(1));
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // interrupt counter, reload and acknowledge
        queue_req(ACT_WRITE, ADDR_ENABLE, 8'hff);
        queue_req(ACT_WRITE, ADDR_PERIOD, 8'd2);
        repeat (3) queue_req(ACT_TICK, 15'h7fff, 8'hff);
        queue_req(ACT_WRITE, ADDR_DISABLE, 8'h00);
        // aliased disable while already disabled gives no acknowledge
        queue_req(ACT_WRITE, 15'h7ffe, 8'h00);
        queue_req(ACT_WRITE, ADDR_MIRROR, 8'h01);
        queue_req(ACT_WRITE, ADDR_PROTECT, 8'hff);
        // program windows in both modes
        queue_req(ACT_WRITE, ADDR_SELECT, 8'h07);
        queue_req(ACT_WRITE, ADDR_DATA, 8'h80);
        queue_req(ACT_WRITE, ADDR_SELECT, 8'h06);
        queue_req(ACT_WRITE, ADDR_DATA, 8'hff);
        queue_req(ACT_PRG, 15'h0000, 8'h00);
        queue_req(ACT_PRG, 15'h4000, 8'h00);
        queue_req(ACT_PRG, 15'h7fff, 8'h00);
        queue_req(ACT_WRITE, ADDR_SELECT, 8'hc0);
        queue_req(ACT_PRG, 15'h1fff, 8'h00);
        queue_req(ACT_PRG, 15'h5fff, 8'h00);
        // character windows with swap, last good address and out of range
        queue_req(ACT_WRITE, ADDR_DATA, 8'hff);
        queue_req(ACT_CHR, 15'h1fff, 8'h00);
        queue_req(ACT_CHR, 15'h2000, 8'h00);
        queue_req(ACT_CHR, 15'h7fff, 8'h00);
        // counter clear forces a reload on the next tick
        queue_req(ACT_WRITE, ADDR_CLEAR, 8'h00);
        queue_req(ACT_TICK, 15'h0000, 8'h00);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            write_cfg(CFG_PRG_BANK_COUNT, prg_counts[p]);
            write_cfg(CFG_MIRROR_DEFAULT, {7'd0, straps[p]});
            // one phase runs without any stalls
            idle_pct = (p == 3) ? 0 : 32;
            repeat (PHASE_ITEMS) queue_random_req();
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
design/mmc3_pkg.sv
design/mmc3_xlate.sv
design/mmc3_state.sv
design/mmc3_bank_mapper_irq_unit.sv
tb/sv/mmc3_bank_mapper_irq_unit_tb.sv
